// ===== src/segmented_prime_sieve_defines.svh =====
// assertion macros for the sieve checker
`ifndef SEGMENTED_PRIME_SIEVE_DEFINES_SVH
`define SEGMENTED_PRIME_SIEVE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SPS_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("sieve check failed");

// antecedent implies consequent in the next cycle
`define SPS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("sieve check failed");

`endif

// ===== src/sps_pkg.sv =====
package sps_pkg;

  localparam int NUMBER_BITS  = 32;
  localparam int ROOT_BITS    = NUMBER_BITS / 2;
  localparam int BASE_WORDS   = 2048;
  localparam int WINDOW_WORDS = 128;
  localparam int BASE_AW      = $clog2(BASE_WORDS);
  localparam int WIN_AW       = $clog2(WINDOW_WORDS);
  localparam int OFF_BITS     = WIN_AW + 5;
  localparam int IDX_BITS     = 7;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_RANGE  = 2'd1;
  localparam logic [1:0] ST_NOT_SIEVED = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX  = 2'd3;

  localparam logic ACT_SIEVE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic REG_BEGIN = 1'b0;
  localparam logic REG_END   = 1'b1;

  typedef struct packed {
    logic [31:0] range_begin;
    logic [31:0] range_end;
  } range_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] prime_flags;
    logic [31:0] word_base;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== src/sps_isqrt.sv =====
module sps_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [sps_pkg::NUMBER_BITS-1:0] n,
  output logic                          done,
  output logic [sps_pkg::ROOT_BITS-1:0] root
);
  import sps_pkg::*;

  // digit by digit square root, two bits of the operand per cycle
  logic [NUMBER_BITS-1:0] op;
  logic [NUMBER_BITS-1:0] res;
  logic [NUMBER_BITS-1:0] one;
  logic                   running;
  logic [NUMBER_BITS:0]   trial;

  assign trial = {1'b0, res} + {1'b0, one};
  assign root  = res[ROOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        op      <= n;
        res     <= '0;
        one     <= {2'b01, {(NUMBER_BITS-2){1'b0}}};
        running <= 1'b1;
      end else if (running) begin
        if ({1'b0, op} >= trial) begin
          op  <= op - trial[NUMBER_BITS-1:0];
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        if (one == {{(NUMBER_BITS-1){1'b0}}, 1'b1}) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/sps_mod.sv =====
module sps_mod (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [sps_pkg::NUMBER_BITS-1:0] dividend,
  input  logic [sps_pkg::ROOT_BITS-1:0]   divisor,
  output logic                            done,
  output logic [sps_pkg::ROOT_BITS-1:0]   rem
);
  import sps_pkg::*;

  // restoring remainder, one dividend bit per cycle
  logic [NUMBER_BITS-1:0]         sh;
  logic [ROOT_BITS:0]             rem_r;
  logic [ROOT_BITS-1:0]           dsr;
  logic [$clog2(NUMBER_BITS)-1:0] cnt;
  logic                           running;
  logic [ROOT_BITS:0]             t;

  assign t   = {rem_r[ROOT_BITS-1:0], sh[NUMBER_BITS-1]};
  assign rem = rem_r[ROOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        sh      <= dividend;
        dsr     <= divisor;
        rem_r   <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        if (t >= {1'b0, dsr}) rem_r <= t - {1'b0, dsr};
        else rem_r <= t;
        sh  <= sh << 1;
        cnt <= cnt + 1'b1;
        if (cnt == {$clog2(NUMBER_BITS){1'b1}}) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/sps_core.sv =====
module sps_core (
  input  logic                         clk,
  input  logic                         rst,
  input  sps_pkg::range_cfg_t          cfg,
  input  logic                         cfg_wr,
  input  logic                         start,
  input  logic                         action,
  input  logic [sps_pkg::IDX_BITS-1:0] word_index,
  output logic                         busy,
  output sps_pkg::result_t             result
);
  import sps_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_CHECK = 13'h0002,
    S_ROOT  = 13'h0004,
    S_CLEAR = 13'h0008,
    S_P_RD  = 13'h0010,
    S_P_CHK = 13'h0020,
    S_B_RD  = 13'h0040,
    S_B_WR  = 13'h0080,
    S_MOD   = 13'h0100,
    S_W_RD  = 13'h0200,
    S_W_WR  = 13'h0400,
    S_R_OUT = 13'h0800,
    S_ROOTW = 13'h1000
  } state_t;

  state_t state;

  logic [31:0] base_mem [BASE_WORDS];
  logic [31:0] win_mem  [WINDOW_WORDS];
  logic [31:0] base_q, win_q;
  logic [BASE_AW-1:0] base_raddr, base_waddr;
  logic [WIN_AW-1:0]  win_raddr, win_waddr;
  logic [31:0] base_wdata, win_wdata;
  logic base_we, win_we;

  logic [NUMBER_BITS-1:0] lo, hi, wbase;
  logic [NUMBER_BITS-5:0] wwords;
  logic [ROOT_BITS-1:0]   r;
  logic [ROOT_BITS:0]     p;
  logic [ROOT_BITS+1:0]   bm;
  logic [NUMBER_BITS:0]   wm;
  logic [BASE_AW-1:0]     cnt, clr_last;
  logic [IDX_BITS-1:0]    idx;
  logic                   sieve_valid;

  logic sq_go, sq_done, mod_go, mod_done;
  logic [ROOT_BITS-1:0] sq_root, mod_rem;
  logic [NUMBER_BITS:0] w_start, w_first, rd_first;
  logic [ROOT_BITS+1:0] two_p;
  logic [OFF_BITS-1:0]  off;
  logic [31:0]          rd_flags;

  assign lo     = cfg.range_begin;
  assign hi     = cfg.range_end;
  assign wbase  = {lo[NUMBER_BITS-1:5], 5'b0};
  assign wwords = {1'b0, hi[NUMBER_BITS-1:5]} - {1'b0, lo[NUMBER_BITS-1:5]} + 1'b1;
  assign busy   = (state != S_IDLE);

  assign sq_go  = (state == S_CHECK);
  assign mod_go = (state == S_B_RD) && ({2'b0, r} < bm);

  sps_isqrt u_isqrt (
    .clk(clk), .rst(rst), .go(sq_go), .n(hi), .done(sq_done), .root(sq_root)
  );

  sps_mod u_mod (
    .clk(clk), .rst(rst), .go(mod_go), .dividend(wbase), .divisor(p[ROOT_BITS-1:0]),
    .done(mod_done), .rem(mod_rem)
  );

  // first window multiple of p, never below 2p
  assign two_p   = {p, 1'b0};
  assign w_first = (mod_rem == '0) ? {1'b0, wbase}
                 : {1'b0, wbase} + {{(NUMBER_BITS-ROOT_BITS){1'b0}}, p}
                   - {{(NUMBER_BITS-ROOT_BITS+1){1'b0}}, mod_rem};
  assign w_start = (w_first < {{(NUMBER_BITS-ROOT_BITS-1){1'b0}}, two_p})
                 ? {{(NUMBER_BITS-ROOT_BITS-1){1'b0}}, two_p} : w_first;
  assign off     = OFF_BITS'(wm - {1'b0, wbase});
  assign clr_last = (r[ROOT_BITS-1:5] > BASE_AW'(WINDOW_WORDS - 1))
                  ? r[ROOT_BITS-1:5] : BASE_AW'(WINDOW_WORDS - 1);

  // read result masking
  assign rd_first = {1'b0, wbase} + {{(NUMBER_BITS-IDX_BITS-4){1'b0}}, idx, 5'b0};
  always_comb begin
    logic [NUMBER_BITS:0] n;
    for (int k = 0; k < 32; k++) begin
      n = rd_first + (NUMBER_BITS+1)'(k);
      rd_flags[k] = (n >= {1'b0, lo}) && (n <= {1'b0, hi}) && (n >= 2) && !win_q[k];
    end
  end

  // memory address and write selection
  always_comb begin
    base_raddr = bm[ROOT_BITS-1:5];
    win_raddr  = off[OFF_BITS-1:5];
    base_we    = 1'b0;
    win_we     = 1'b0;
    base_waddr = bm[ROOT_BITS-1:5];
    win_waddr  = off[OFF_BITS-1:5];
    base_wdata = base_q | (32'd1 << bm[4:0]);
    win_wdata  = win_q | (32'd1 << off[4:0]);
    unique case (state)
      S_IDLE: win_raddr = word_index;
      S_P_RD: base_raddr = p[ROOT_BITS-1:5];
      S_CLEAR: begin
        base_waddr = cnt;
        win_waddr  = cnt[WIN_AW-1:0];
        base_wdata = '0;
        win_wdata  = '0;
        base_we    = (cnt <= r[ROOT_BITS-1:5]);
        win_we     = (cnt < BASE_AW'(WINDOW_WORDS));
      end
      S_B_WR: base_we = 1'b1;
      S_W_WR: win_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_waddr] <= base_wdata;
    base_q <= base_mem[base_raddr];
  end

  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    win_q <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sieve_valid  <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      result.valid <= 1'b0;
      if (cfg_wr) sieve_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            idx <= word_index;
            if (action == ACT_SIEVE) begin
              state <= S_CHECK;
            end else begin
              state <= S_R_OUT;
            end
          end
        end
        S_CHECK: state <= S_ROOT;
        S_ROOT: begin
          if (lo > hi || wwords > (NUMBER_BITS-4)'(WINDOW_WORDS)) begin
            sieve_valid        <= 1'b0;
            result.valid       <= 1'b1;
            result.prime_flags <= '0;
            result.word_base   <= wbase[31:0];
            result.status      <= ST_BAD_RANGE;
            state              <= S_IDLE;
          end else begin
            state <= S_ROOTW;
          end
        end
        S_ROOTW: begin
          if (sq_done) begin
            r   <= sq_root;
            cnt <= '0;
            if ({1'b0, sq_root} >= (ROOT_BITS+1)'(BASE_WORDS * 32)) begin
              sieve_valid        <= 1'b0;
              result.valid       <= 1'b1;
              result.prime_flags <= '0;
              result.word_base   <= wbase[31:0];
              result.status      <= ST_BAD_RANGE;
              state              <= S_IDLE;
            end else begin
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == clr_last) begin
            p     <= (ROOT_BITS+1)'(2);
            state <= S_P_RD;
          end
        end
        S_P_RD: begin
          if (p > {1'b0, r}) begin
            sieve_valid        <= 1'b1;
            result.valid       <= 1'b1;
            result.prime_flags <= '0;
            result.word_base   <= wbase[31:0];
            result.status      <= ST_OK;
            state              <= S_IDLE;
          end else begin
            state <= S_P_CHK;
          end
        end
        S_P_CHK: begin
          if (base_q[p[4:0]]) begin
            p     <= p + 1'b1;
            state <= S_P_RD;
          end else begin
            bm    <= {p, 1'b0};
            state <= S_B_RD;
          end
        end
        S_B_RD: begin
          if ({2'b0, r} < bm) state <= S_MOD;
          else state <= S_B_WR;
        end
        S_B_WR: begin
          bm    <= bm + {1'b0, p};
          state <= S_B_RD;
        end
        S_MOD: begin
          if (mod_done) begin
            wm    <= w_start;
            state <= S_W_RD;
          end
        end
        S_W_RD: begin
          if (wm > {1'b0, hi}) begin
            p     <= p + 1'b1;
            state <= S_P_RD;
          end else begin
            state <= S_W_WR;
          end
        end
        S_W_WR: begin
          wm    <= wm + {{(NUMBER_BITS-ROOT_BITS){1'b0}}, p};
          state <= S_W_RD;
        end
        S_R_OUT: begin
          result.valid     <= 1'b1;
          result.word_base <= rd_first[31:0];
          if (!sieve_valid) begin
            result.status      <= ST_NOT_SIEVED;
            result.prime_flags <= '0;
          end else if ({{(NUMBER_BITS-4-IDX_BITS){1'b0}}, idx} >= wwords) begin
            result.status      <= ST_BAD_INDEX;
            result.prime_flags <= '0;
          end else begin
            result.status      <= ST_OK;
            result.prime_flags <= rd_flags;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/segmented_prime_sieve.sv =====
// segmented prime sieve over a configured range [range_begin, range_end]
// configuration: apb-style port, range_begin at 0x0, range_end at 0x4; a write
//   transfer clears the sieved flag, reads return the register value
// commands: a transfer happens when start is high and busy is low
//   action 0 sieves the range, action 1 reads window word word_index
// results: one per command, shown for exactly one cycle with done high;
//   the receiver cannot stall, so a result is never held back
// sequence: a read goes straight to the output state; a sieve runs the square
//   root, a clearing pass over both bitmaps, a check of each candidate base
//   number, and for each base prime a read and a write per marked multiple in
//   the base map, the remainder, then a read and a write per marked multiple
//   in the window map
// one command at a time: busy stays high until the result cycle
// reset: synchronous, clears both range registers, the sieved flag and the
//   sequencer; the bitmaps hold no reset and are cleared by each sieve whose range is valid
module segmented_prime_sieve (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [sps_pkg::IDX_BITS-1:0] word_index,
  output logic                         done,
  output logic [31:0]                  prime_flags,
  output logic [31:0]                  word_base,
  output logic [1:0]                   status
);
  import sps_pkg::*;

  range_cfg_t cfg;
  result_t    result;
  logic       cfg_wr;

  // register write on the access phase of a write transfer
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_begin <= '0;
      cfg.range_end   <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BEGIN) cfg.range_begin <= pwdata;
      else cfg.range_end <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_END) ? cfg.range_end : cfg.range_begin;

  // sequencer with both bitmaps, the root unit and the remainder unit
  sps_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_wr     (cfg_wr),
    .start      (start),
    .action     (action),
    .word_index (word_index),
    .busy       (busy),
    .result     (result)
  );

  assign done        = result.valid;
  assign prime_flags = result.prime_flags;
  assign word_base   = result.word_base;
  assign status      = result.status;
endmodule

// ===== src/sps_checker.sv =====
`include "segmented_prime_sieve_defines.svh"

module sps_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] prime_flags,
  input logic [1:0]  status
);
  import sps_pkg::*;

  // an accepted command keeps the block busy in the next cycle
  `SPS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // results never come in back-to-back cycles
  `SPS_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // a result closes a busy stretch
  `SPS_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy))
  // error results carry no prime flags
  `SPS_ASSERT_NOW(a_err_no_flags, clk, rst, done && status != ST_OK, prime_flags == '0)
endmodule

bind segmented_prime_sieve sps_checker u_sps_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .prime_flags(prime_flags), .status(status)
);

// ===== dv/segmented_prime_sieve_test.sv =====
module segmented_prime_sieve_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  // longest quiet stretch allowed, for a full 32-bit window sieve
  localparam int QUIET_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic {JOB_CMD, JOB_CFG} job_kind_e;

  typedef struct {
    job_kind_e   kind;
    logic        act;
    logic [6:0]  idx;
    logic        regsel;
    logic [31:0] value;
  } job_t;

  typedef struct {
    logic [31:0] flags;
    logic [31:0] base;
    logic [1:0]  st;
  } word_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic        action;
  logic [6:0]  word_index;
  logic        done;
  logic [31:0] prime_flags;
  logic [31:0] word_base;
  logic [1:0]  status;

  segmented_prime_sieve dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .action(action), .word_index(word_index),
    .done(done), .prime_flags(prime_flags), .word_base(word_base), .status(status)
  );

  // pending stimulus and the results still owed by the block
  job_t         job_q[$];
  word_result_t owed_q[$];
  bit           failed;
  int           accepted;
  int           quiet;

  // predictor state: range registers, sieved flag, window composite bits
  logic [31:0] cfg_begin;
  logic [31:0] cfg_end;
  bit          sieved;
  bit [31:0]   win_map[WINDOW_WORDS];
  bit          base_comp[65536];

  // sieve the configured range into win_map, return the status
  function automatic logic [1:0] sieve_range();
    longint unsigned lo, hi, wbase, root, p, m, first, off;
    lo = cfg_begin;
    hi = cfg_end;
    wbase = lo & ~64'd31;
    foreach (win_map[i]) win_map[i] = '0;
    foreach (base_comp[i]) base_comp[i] = 0;
    sieved = 0;
    if (lo > hi) return ST_BAD_RANGE;
    if ((hi >> 5) - (lo >> 5) + 1 > WINDOW_WORDS) return ST_BAD_RANGE;
    root = 0;
    while ((root + 1) * (root + 1) <= hi) root++;
    if (root >= BASE_WORDS * 32) return ST_BAD_RANGE;
    // 0 and 1 are never prime
    if (wbase == 0) begin
      win_map[0][0] = 1'b1;
      win_map[0][1] = 1'b1;
    end
    for (p = 2; p <= root; p++) begin
      if (base_comp[p]) continue;
      for (m = 2 * p; m <= root; m += p) base_comp[m] = 1;
      first = ((wbase + p - 1) / p) * p;
      if (first < 2 * p) first = 2 * p;
      for (m = first; m <= hi; m += p) begin
        off = m - wbase;
        win_map[(off >> 5) % WINDOW_WORDS][off[4:0]] = 1'b1;
      end
    end
    sieved = 1;
    return ST_OK;
  endfunction

  function automatic word_result_t predict_word(logic act, logic [6:0] idx);
    word_result_t    res;
    longint unsigned lo, hi, wbase, first, n;
    lo = cfg_begin;
    hi = cfg_end;
    wbase = lo & ~64'd31;
    res.flags = '0;
    if (act == ACT_SIEVE) begin
      res.st = sieve_range();
      res.base = wbase[31:0];
      return res;
    end
    first = wbase + 64'(idx) * 32;
    res.base = first[31:0];
    if (!sieved) res.st = ST_NOT_SIEVED;
    else if (idx >= (hi >> 5) - (lo >> 5) + 1) res.st = ST_BAD_INDEX;
    else begin
      res.st = ST_OK;
      for (int k = 0; k < 32; k++) begin
        n = first + k;
        if (n >= lo && n <= hi && n >= 2 && !win_map[idx][k]) res.flags[k] = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic push_cfg(logic regsel, logic [31:0] value);
    job_t j;
    j.kind = JOB_CFG;
    j.act = ACT_SIEVE;
    j.idx = '0;
    j.regsel = regsel;
    j.value = value;
    job_q.push_back(j);
  endtask

  task automatic push_cmd(logic act, logic [6:0] idx);
    job_t j;
    j.kind = JOB_CMD;
    j.act = act;
    j.idx = idx;
    j.regsel = REG_BEGIN;
    j.value = '0;
    job_q.push_back(j);
  endtask

  task automatic push_range(logic [31:0] lo, logic [31:0] hi);
    push_cfg(REG_BEGIN, lo);
    push_cfg(REG_END, hi);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: one job at a time, apb setup/access for config, start for commands
  int drv_phase;

  always @(posedge clk) begin
    job_t j;
    bit   rest;
    if (rst) begin
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      start <= 1'b0;
      action <= ACT_SIEVE;
      word_index <= '0;
      drv_phase <= 0;
    end else begin
      // random quiet cycles, none in the middle of the run
      rest = (accepted < 40 || accepted > 75) && ($urandom_range(0, 99) < 26);
      case (drv_phase)
        0: begin
          if (job_q.size() > 0 && !rest) begin
            j = job_q[0];
            if (j.kind == JOB_CFG) begin
              // registers only change while the block is idle
              if (owed_q.size() == 0 && !busy) begin
                psel <= 1'b1;
                pwrite <= 1'b1;
                paddr <= {j.regsel, 2'b00};
                pwdata <= j.value;
                drv_phase <= 1;
              end
            end else begin
              start <= 1'b1;
              action <= j.act;
              word_index <= j.idx;
              drv_phase <= 2;
            end
          end
        end
        1: begin
          penable <= 1'b1;
          drv_phase <= 3;
        end
        2: begin
          // command transfer
          if (!busy) begin
            j = job_q.pop_front();
            owed_q.push_back(predict_word(j.act, j.idx));
            accepted++;
            start <= 1'b0;
            drv_phase <= 0;
          end
        end
        3: begin
          // register write transfer
          if (pready) begin
            j = job_q.pop_front();
            if (j.regsel == REG_BEGIN) cfg_begin = j.value;
            else cfg_end = j.value;
            sieved = 0;
            accepted++;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            drv_phase <= 0;
          end
        end
        default: drv_phase <= 0;
      endcase
    end
  end

  // monitor: every done cycle is one result transfer
  always @(posedge clk) begin
    word_result_t e;
    if (!rst) begin
      if (done) begin
        quiet <= 0;
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result flags %h base %h status %0d",
                   $time, prime_flags, word_base, status);
          failed = 1;
        end else begin
          e = owed_q.pop_front();
          if (prime_flags !== e.flags) begin
            $display("%0t: prime_flags expected %h actual %h", $time, e.flags, prime_flags);
            failed = 1;
          end
          if (word_base !== e.base) begin
            $display("%0t: word_base expected %h actual %h", $time, e.base, word_base);
            failed = 1;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            failed = 1;
          end
        end
      end else if ((start && !busy) || (psel && penable && pready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [31:0] lo, hi;
    int          words;
    failed = 0;
    accepted = 0;
    quiet = 0;
    cfg_begin = '0;
    cfg_end = '0;
    sieved = 0;

    // directed: read before any sieve, tiny ranges, bad ranges, extremes
    push_cmd(ACT_READ, 7'd0);
    push_cmd(ACT_SIEVE, 7'd127);
    push_cmd(ACT_READ, 7'd0);
    push_range(32'd0, 32'd100);
    push_cmd(ACT_SIEVE, 7'd0);
    push_cmd(ACT_READ, 7'd0);
    push_cmd(ACT_READ, 7'd3);
    push_cmd(ACT_READ, 7'd4);
    push_cmd(ACT_READ, 7'd127);
    push_cfg(REG_END, 32'd90);
    push_cmd(ACT_READ, 7'd0);
    push_range(32'd50, 32'd10);
    push_cmd(ACT_SIEVE, 7'd0);
    push_cmd(ACT_READ, 7'd0);
    push_range(32'd0, 32'd5000);
    push_cmd(ACT_SIEVE, 7'd0);
    push_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(ACT_SIEVE, 7'd0);
    push_cmd(ACT_READ, 7'd0);
    push_range(32'hFFFF_F000, 32'hFFFF_FFFF);
    push_cmd(ACT_SIEVE, 7'd0);
    push_cmd(ACT_READ, 7'd0);
    push_cmd(ACT_READ, 7'd127);
    push_cmd(ACT_READ, 7'd85);

    // random: mostly well-formed range, sieve, reads; some broken ranges
    for (int ph = 0; ph < 14; ph++) begin
      if ($urandom_range(0, 99) < 80) begin
        lo = $urandom_range(0, 1 << 20);
        words = $urandom_range(1, 128);
        hi = (lo & ~32'd31) + words * 32 - 1 - $urandom_range(0, 31);
        if (hi < lo) hi = lo;
      end else begin
        lo = $urandom;
        hi = $urandom;
        words = 1;
      end
      push_range(lo, hi);
      push_cmd(ACT_SIEVE, 7'($urandom));
      for (int r = 0; r < 6; r++) begin
        if ($urandom_range(0, 3) == 0) push_cmd(ACT_READ, 7'($urandom));
        else push_cmd(ACT_READ, 7'($urandom_range(0, words - 1)));
      end
    end

    while (job_q.size() != 0 || owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && owed_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
